// ===== src/amb_pkg.sv =====
// ----------------------------------------------------------------------------
// amb_pkg
// Shared types and codes for the adjacency-matrix breadth-first search block.
// ----------------------------------------------------------------------------
package amb_pkg;

    // Operation codes of an input beat
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    // Visit order reported for a vertex the search never reached
    localparam logic signed [3:0] NOT_REACHED = -4'sd1;

    // Widths of the fixed item fields
    localparam int VTX_W = 3;
    localparam int ORD_W = 4;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

// ===== src/adjacency_matrix_bfs_order.sv =====
// ----------------------------------------------------------------------------
// adjacency_matrix_bfs_order
// Keeps an undirected graph as a symmetric adjacency bit matrix and numbers
// the vertices in breadth-first discovery order from a chosen start vertex.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+----------------------------------
//  input   | in        | i_valid / o_stall | i_op, i_vertex_a, i_vertex_b
//  result  | out       | o_valid / i_stall | o_vertex_index, o_visit_order,
//          |           |                   | o_last
//
//  Insert and remove beats give no result.
//  A search gives N = min(VERTICES, 8) results, also when the start vertex
//  is out of range. Each reached vertex is dequeued once and its neighbours
//  scanned, each vertex past the start is enqueued through the shared
//  lowest-bit picker, and a final dequeue finds the queue empty.
//  o_stall stays high from a search beat until its last result is loaded.
//  A stalled result holds the output register; emission waits on it.
//  Reset clears the matrix, visit marks and the sequencer.
//
module adjacency_matrix_bfs_order #(
    parameter int VERTICES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_op,
    input  logic [amb_pkg::VTX_W-1:0]       i_vertex_a,
    input  logic [amb_pkg::VTX_W-1:0]       i_vertex_b,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [amb_pkg::VTX_W-1:0]       o_vertex_index,
    output logic signed [amb_pkg::ORD_W-1:0] o_visit_order,
    output logic                            o_last
);

    // Vertex fields are three bits wide, so only the first eight vertices
    // can ever carry edges, be searched from or be reported.
    localparam int RV = (VERTICES < 8) ? VERTICES : 8;
    localparam int IW = (RV > 1) ? $clog2(RV) : 1;
    localparam int CW = $clog2(RV + 1);

    amb_pkg::t_state r_state, n_state;

    logic [RV-1:0] r_adj [RV];
    logic [RV-1:0] r_visited;
    logic [IW-1:0] r_order [RV];
    logic [IW-1:0] r_fifo  [RV];
    logic [CW-1:0] r_head;
    logic [CW-1:0] r_tail;
    logic [RV-1:0] r_scan;
    logic [IW-1:0] r_emit;

    logic                           r_out_valid;
    logic [amb_pkg::VTX_W-1:0]      r_out_index;
    logic signed [amb_pkg::ORD_W-1:0] r_out_order;
    logic                           r_out_last;

    logic          in_beat;
    logic          a_ok, b_ok;
    logic [IW-1:0] a_idx, b_idx;
    logic          pick_found;
    logic [IW-1:0] pick_idx;
    logic [IW-1:0] cur;
    logic          out_load;

    assign in_beat = i_valid && !o_stall;
    assign a_ok    = ({1'b0, i_vertex_a} < 4'(RV));
    assign b_ok    = ({1'b0, i_vertex_b} < 4'(RV));
    assign a_idx   = i_vertex_a[IW-1:0];
    assign b_idx   = i_vertex_b[IW-1:0];
    assign cur     = r_fifo[r_head[IW-1:0]];

    // Shared picker: lowest pending neighbour of the current vertex
    always_comb begin
        pick_found = 1'b0;
        pick_idx   = '0;
        for (int i = 0; i < RV; i++) begin
            if (r_scan[i] && !pick_found) begin
                pick_found = 1'b1;
                pick_idx   = IW'(i);
            end
        end
    end

    // Sequencer next state and strobes
    always_comb begin
        n_state  = r_state;
        o_stall  = (r_state != amb_pkg::ST_IDLE);
        out_load = 1'b0;
        unique case (r_state)
            amb_pkg::ST_IDLE: begin
                if (in_beat && i_op == amb_pkg::OP_SEARCH) begin
                    n_state = amb_pkg::ST_POP;
                end
            end
            amb_pkg::ST_POP: begin
                n_state = (r_head < r_tail) ? amb_pkg::ST_SCAN : amb_pkg::ST_EMIT;
            end
            amb_pkg::ST_SCAN: begin
                if (!pick_found) begin
                    n_state = amb_pkg::ST_POP;
                end
            end
            amb_pkg::ST_EMIT: begin
                out_load = !r_out_valid || !i_stall;
                if (out_load && r_emit == IW'(RV - 1)) begin
                    n_state = amb_pkg::ST_IDLE;
                end
            end
            default: n_state = amb_pkg::ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= amb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Adjacency matrix: set or clear both symmetric bits, the diagonal once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < RV; r++) begin
                r_adj[r] <= '0;
            end
        end else if (in_beat && a_ok && b_ok &&
                     (i_op == amb_pkg::OP_INSERT || i_op == amb_pkg::OP_REMOVE)) begin
            r_adj[a_idx][b_idx] <= (i_op == amb_pkg::OP_INSERT);
            if (a_idx != b_idx) begin
                r_adj[b_idx][a_idx] <= (i_op == amb_pkg::OP_INSERT);
            end
        end
    end

    // Search control: visit marks, queue pointers, scan mask, emit index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_scan    <= '0;
            r_emit    <= '0;
        end else begin
            unique case (r_state)
                amb_pkg::ST_IDLE: begin
                    if (in_beat && i_op == amb_pkg::OP_SEARCH) begin
                        r_head <= '0;
                        r_emit <= '0;
                        r_scan <= '0;
                        if (a_ok) begin
                            r_visited        <= RV'(1) << a_idx;
                            r_tail           <= CW'(1);
                        end else begin
                            r_visited <= '0;
                            r_tail    <= '0;
                        end
                    end
                end
                amb_pkg::ST_POP: begin
                    if (r_head < r_tail) begin
                        r_head <= r_head + CW'(1);
                        r_scan <= r_adj[cur] & ~r_visited;
                    end
                end
                amb_pkg::ST_SCAN: begin
                    if (pick_found) begin
                        r_visited[pick_idx] <= 1'b1;
                        r_scan[pick_idx]    <= 1'b0;
                        r_tail              <= r_tail + CW'(1);
                    end
                end
                amb_pkg::ST_EMIT: begin
                    if (out_load) begin
                        r_emit <= r_emit + IW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Queue entries and visit numbers: the tail count is the discovery number
    always_ff @(posedge i_clk) begin
        if (r_state == amb_pkg::ST_IDLE && in_beat && i_op == amb_pkg::OP_SEARCH && a_ok) begin
            r_fifo[0]      <= a_idx;
            r_order[a_idx] <= '0;
        end else if (r_state == amb_pkg::ST_SCAN && pick_found) begin
            r_fifo[r_tail[IW-1:0]] <= pick_idx;
            r_order[pick_idx]      <= r_tail[IW-1:0];
        end
    end

    // Result output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_index <= amb_pkg::VTX_W'(r_emit);
            r_out_order <= r_visited[r_emit] ? amb_pkg::ORD_W'(r_order[r_emit])
                                             : amb_pkg::NOT_REACHED;
            r_out_last  <= (r_emit == IW'(RV - 1));
        end
    end

    assign o_valid        = r_out_valid;
    assign o_vertex_index = r_out_index;
    assign o_visit_order  = r_out_order;
    assign o_last         = r_out_last;

    // Every marked vertex was enqueued exactly once
    a_marks_match_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_visited) == 32'(r_tail))
        else $error("visit marks disagree with queue tail");

    // Queue never dequeues past what it enqueued
    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");

    // Scan mask only holds undiscovered vertices
    a_scan_unvisited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan & r_visited) == '0)
        else $error("scan mask holds a visited vertex");

    // Last flag only on the highest reported vertex
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_vertex_index == amb_pkg::VTX_W'(RV - 1)))
        else $error("last flag on wrong vertex");

    // A search beat always leads into the dequeue step
    a_search_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && i_op == amb_pkg::OP_SEARCH) |=> (r_state == amb_pkg::ST_POP))
        else $error("search beat did not start the sequencer");

endmodule
